FILE: sv/covered_segment_window_filter_assert.svh
// Assertion macros used by the window filter checker.
`ifndef COVERED_SEGMENT_WINDOW_FILTER_ASSERT_SVH
`define COVERED_SEGMENT_WINDOW_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("window filter assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("window filter assertion failed");

`endif

FILE: sv/csw_pkg.sv
// Shared types and constants for the covered segment window filter.
`default_nettype none

package csw_pkg;

   localparam int CSW_FIELD_WIDTH = 16;
   localparam int CSW_LIMIT_WIDTH = 7;
   localparam logic [CSW_LIMIT_WIDTH-1:0] CSW_LIMIT_RESET = 7'd8;

   // Input beat
   typedef struct packed {
      logic                       func;
      logic [CSW_FIELD_WIDTH-1:0] q_start;
      logic [CSW_FIELD_WIDTH-1:0] s_start;
      logic [CSW_FIELD_WIDTH-1:0] seg_length;
      logic [CSW_FIELD_WIDTH-1:0] seg_score;
   } csw_req_type;

   // Result beat
   typedef struct packed {
      logic [CSW_FIELD_WIDTH-1:0] out_q_start;
      logic [CSW_FIELD_WIDTH-1:0] out_s_start;
      logic [CSW_FIELD_WIDTH-1:0] out_length;
      logic [CSW_FIELD_WIDTH-1:0] out_score;
      logic                       early_evicted;
      logic                       last;
   } csw_rsp_type;

   // Controller to result stage: push a new result, or close the item
   typedef struct packed {
      logic        push;
      logic        finish;
      csw_rsp_type data;
   } csw_res_cmd_type;

   // Result stage to controller
   typedef struct packed {
      logic pend_valid;
      logic out_free;
   } csw_res_status_type;

   typedef enum logic [1:0] {
      CSW_IDLE,
      CSW_WALK,
      CSW_PLACE,
      CSW_DRAIN
   } csw_state_type;

endpackage

`default_nettype wire

FILE: sv/covered_segment_window_filter.sv
// Top level of the covered segment window filter.
// One item at a time: the input stalls from acceptance through the walk over the window entries,
// then placement (segments only) and the drain of the held result, and longer while a result
// waits on a stalled output.
// Each result is held back one beat until the next result or the end of its item settles last.
// Synchronous reset empties the window and sets the cover limit to 8; no clearing pass.
`default_nettype none

module covered_segment_window_filter import csw_pkg::*; #(
   parameter int WINDOW_DEPTH   = 32,
   parameter int POSITION_WIDTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire csw_req_type                req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output csw_rsp_type                     rsp_data,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSW_LIMIT_WIDTH-1:0] csr_wr_data
);

   localparam int AW      = $clog2(WINDOW_DEPTH);
   localparam int ENTRY_W = 3 * POSITION_WIDTH + CSW_FIELD_WIDTH;

   logic               mem_wr_en, mem_rd_en;
   logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
   logic [ENTRY_W-1:0] mem_wr_data, mem_rd_data;
   csw_res_cmd_type    res_cmd;
   csw_res_status_type res_status;

   csw_window_mem #(
      .DEPTH (WINDOW_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   csw_walk_ctrl #(
      .DEPTH   (WINDOW_DEPTH),
      .POS_W   (POSITION_WIDTH),
      .ENTRY_W (ENTRY_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .res_cmd     (res_cmd),
      .res_status  (res_status)
   );

   csw_result_stage u_result (
      .clock      (clock),
      .reset      (reset),
      .res_cmd    (res_cmd),
      .res_status (res_status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

FILE: sv/csw_window_mem.sv
// Window entry store: one write port, one read port, registered read data.
`default_nettype none

module csw_window_mem #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/csw_result_stage.sv
// Result stage: one pending result to decide last, then the output register.
`default_nettype none

module csw_result_stage import csw_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire csw_res_cmd_type    res_cmd,
   output csw_res_status_type      res_status,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output csw_rsp_type             rsp_data
);

   logic        pend_valid_ff, pend_valid_in;
   csw_rsp_type pend_ff, pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   csw_rsp_type rsp_data_ff, rsp_data_in;
   logic        move;

   assign res_status.pend_valid = pend_valid_ff;
   assign res_status.out_free   = !rsp_valid_ff || !rsp_stall;

   // Pending result moves out when a newer one arrives or the item closes
   assign move = (res_cmd.push || res_cmd.finish) && pend_valid_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (move) begin
         rsp_valid_in     = 1'b1;
         rsp_data_in      = pend_ff;
         rsp_data_in.last = res_cmd.finish;
      end
      if (res_cmd.push) begin
         pend_valid_in = 1'b1;
         pend_in       = res_cmd.data;
      end else if (res_cmd.finish) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: sv/csw_walk_ctrl.sv
// Window walk controller: expiry, cover count, compaction and placement.
`default_nettype none

module csw_walk_ctrl import csw_pkg::*; #(
   parameter int DEPTH  = 32,
   parameter int POS_W  = 16,
   parameter int ENTRY_W = 3 * POS_W + CSW_FIELD_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire csw_req_type                req_data,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSW_LIMIT_WIDTH-1:0] csr_wr_data,
   output logic                            mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]        mem_wr_addr,
   output logic [ENTRY_W-1:0]              mem_wr_data,
   output logic                            mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]        mem_rd_addr,
   input  wire logic [ENTRY_W-1:0]         mem_rd_data,
   output csw_res_cmd_type                 res_cmd,
   input  wire csw_res_status_type         res_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [POS_W-1:0]           qpos;
      logic [POS_W-1:0]           spos;
      logic [POS_W-1:0]           len;
      logic [CSW_FIELD_WIDTH-1:0] score;
   } entry_type;

   csw_state_type              state_ff, state_in;
   entry_type                  cur_ff, cur_in;
   entry_type                  first_ff, first_in;
   logic                       func_ff, func_in;
   logic [AW-1:0]              head_ff, head_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              kept_ff, kept_in;
   logic [CW-1:0]              covers_ff, covers_in;
   logic [CSW_LIMIT_WIDTH-1:0] limit_ff;

   entry_type      rd_entry;
   logic [POS_W:0] e_end, cur_end;
   logic           expire, cover_hit, go, advance;
   logic [CW-1:0]  idx_next, kept_next;

   // Circular index: base plus offset, folded once into the window
   function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
      logic [AW+1:0] s;
      s = (AW+2)'(base) + (AW+2)'(off);
      if (s >= (AW+2)'(DEPTH)) begin
         s = s - (AW+2)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   function automatic csw_rsp_type to_rsp(input entry_type e, input logic early);
      csw_rsp_type r;
      r.out_q_start   = CSW_FIELD_WIDTH'(e.qpos);
      r.out_s_start   = CSW_FIELD_WIDTH'(e.spos);
      r.out_length    = CSW_FIELD_WIDTH'(e.len);
      r.out_score     = e.score;
      r.early_evicted = early;
      r.last          = 1'b0;
      return r;
   endfunction

   // Per-entry tests on the entry just read
   assign rd_entry  = entry_type'(mem_rd_data);
   assign e_end     = {1'b0, rd_entry.spos} + {1'b0, rd_entry.len};
   assign cur_end   = {1'b0, cur_ff.spos} + {1'b0, cur_ff.len};
   assign expire    = func_ff || (e_end <= {1'b0, cur_ff.spos});
   assign cover_hit = (rd_entry.score >= cur_ff.score) && (rd_entry.spos <= cur_ff.spos)
                      && (e_end >= cur_end);
   assign go        = !res_status.pend_valid || res_status.out_free;
   assign advance   = !expire || go;
   assign idx_next  = idx_ff + 1'b1;
   assign kept_next = expire ? kept_ff : kept_ff + 1'b1;

   assign req_stall = (state_ff != CSW_IDLE);

   // Next state and datapath control
   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      first_in    = first_ff;
      func_in     = func_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      kept_in     = kept_ff;
      covers_in   = covers_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = head_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = head_ff;
      mem_wr_data = cur_ff;
      res_cmd     = '0;
      case (state_ff)
         CSW_IDLE: begin
            if (req_valid) begin
               cur_in.qpos  = POS_W'(req_data.q_start);
               cur_in.spos  = POS_W'(req_data.s_start);
               cur_in.len   = POS_W'(req_data.seg_length);
               cur_in.score = req_data.seg_score;
               func_in      = req_data.func;
               idx_in       = '0;
               kept_in      = '0;
               covers_in    = '0;
               if (count_ff != '0) begin
                  mem_rd_en = 1'b1;
                  state_in  = CSW_WALK;
               end else if (req_data.func) begin
                  state_in = CSW_DRAIN;
               end else begin
                  state_in = CSW_PLACE;
               end
            end
         end
         CSW_WALK: begin
            res_cmd.data = to_rsp(rd_entry, 1'b0);
            if (expire) begin
               res_cmd.push = go;
            end else begin
               // Survivor is packed down to the next kept slot
               mem_wr_en   = 1'b1;
               mem_wr_addr = wrap_addr(head_ff, kept_ff);
               mem_wr_data = rd_entry;
               kept_in     = kept_next;
               covers_in   = covers_ff + CW'(cover_hit);
            end
            if (advance) begin
               if (idx_ff == '0) begin
                  first_in = rd_entry;
               end
               idx_in = idx_next;
               if (idx_next < count_ff) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = wrap_addr(head_ff, idx_next);
               end else begin
                  count_in = kept_next;
                  state_in = func_ff ? CSW_DRAIN : CSW_PLACE;
               end
            end
         end
         CSW_PLACE: begin
            if (CSW_LIMIT_WIDTH'(covers_ff) <= limit_ff) begin
               if (count_ff == CW'(DEPTH)) begin
                  // Full window: oldest leaves early, new segment takes its slot
                  res_cmd.data = to_rsp(first_ff, 1'b1);
                  if (go) begin
                     res_cmd.push = 1'b1;
                     mem_wr_en    = 1'b1;
                     mem_wr_addr  = head_ff;
                     head_in      = wrap_addr(head_ff, CW'(1));
                     state_in     = CSW_DRAIN;
                  end
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = wrap_addr(head_ff, count_ff);
                  count_in    = count_ff + 1'b1;
                  state_in    = CSW_DRAIN;
               end
            end else begin
               state_in = CSW_DRAIN;
            end
         end
         CSW_DRAIN: begin
            if (!res_status.pend_valid) begin
               state_in = CSW_IDLE;
            end else if (res_status.out_free) begin
               res_cmd.finish = 1'b1;
               state_in       = CSW_IDLE;
            end
         end
         default: begin
            state_in = CSW_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CSW_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         limit_ff <= CSW_LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      first_ff  <= first_in;
      func_ff   <= func_in;
      idx_ff    <= idx_in;
      kept_ff   <= kept_in;
      covers_ff <= covers_in;
   end

endmodule

`default_nettype wire

FILE: sv/csw_checker.sv
// Port-level checker for the window filter, bound to the top level.
`default_nettype none

`include "covered_segment_window_filter_assert.svh"

module csw_checker import csw_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire csw_rsp_type rsp_data
);

   // Stalled result beat stays and holds its payload
   `CSW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `CSW_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

   // Ready for an item straight after reset
   `CSW_ASSERT_SAME(a_ready_after_reset, clock, reset, $past(reset), !req_stall)

   // One item at a time: an accepted beat closes the input in the cycle after
   `CSW_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall)

   // An early eviction is always the final result of its item
   `CSW_ASSERT_SAME(a_evict_last, clock, reset, rsp_valid && rsp_data.early_evicted,
      rsp_data.last)

endmodule

bind covered_segment_window_filter csw_checker u_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the covered segment window filter: predicts every emitted beat.

import csw_pkg::*;

localparam int WINDOW_SLOTS = 32;
localparam logic FUNC_SEGMENT = 1'b0;
localparam logic FUNC_FLUSH = 1'b1;

typedef struct {
   logic [CSW_FIELD_WIDTH-1:0] qpos;
   logic [CSW_FIELD_WIDTH-1:0] spos;
   logic [CSW_FIELD_WIDTH-1:0] len;
   logic [CSW_FIELD_WIDTH-1:0] score;
} held_seg_type;

// Shapes of the well-formed segment sets used by the random part
typedef enum int {
   SET_CROWDED,
   SET_LONG_LIVED,
   SET_SCATTERED,
   SET_MIXED
} set_style_type;

// Window predictor plus the queue of result beats still awaited
class segment_window_tracker;
   held_seg_type window[WINDOW_SLOTS];
   int unsigned fill;
   logic [CSW_LIMIT_WIDTH-1:0] cover_limit;
   csw_rsp_type awaited_emits[$];
   int unsigned items_taken, flushes, dropped, evictions, emits_checked, mismatches;

   function new();
      fill = 0;
      cover_limit = CSW_LIMIT_RESET;
      items_taken = 0;
      flushes = 0;
      dropped = 0;
      evictions = 0;
      emits_checked = 0;
      mismatches = 0;
   endfunction

   function void queue_emit(held_seg_type s, logic early);
      csw_rsp_type r;
      r.out_q_start = s.qpos;
      r.out_s_start = s.spos;
      r.out_length = s.len;
      r.out_score = s.score;
      r.early_evicted = early;
      r.last = 1'b0;
      awaited_emits = {awaited_emits, r};
   endfunction

   // Work out the beats caused by one accepted input beat
   function void take_item(csw_req_type item);
      held_seg_type cur;
      logic [CSW_FIELD_WIDTH:0] cur_end, e_end;
      int unsigned kept, covers, queued_before, k;
      csw_rsp_type tail;
      queued_before = awaited_emits.size();
      items_taken++;
      if (item.func == FUNC_FLUSH) begin
         flushes++;
         for (k = 0; k < fill; k++) queue_emit(window[k], 1'b0);
         fill = 0;
      end else begin
         cur.qpos = item.q_start;
         cur.spos = item.s_start;
         cur.len = item.seg_length;
         cur.score = item.seg_score;
         cur_end = {1'b0, cur.spos} + cur.len;
         kept = 0;
         covers = 0;
         // expired entries leave in window order; survivors are compacted
         for (k = 0; k < fill; k++) begin
            e_end = {1'b0, window[k].spos} + window[k].len;
            if (e_end > {1'b0, cur.spos}) begin
               if (window[k].score >= cur.score && window[k].spos <= cur.spos &&
                   e_end >= cur_end)
                  covers++;
               window[kept] = window[k];
               kept++;
            end else begin
               queue_emit(window[k], 1'b0);
            end
         end
         fill = kept;
         if (covers <= cover_limit) begin
            // full window: oldest entry goes out early
            if (fill >= WINDOW_SLOTS) begin
               queue_emit(window[0], 1'b1);
               evictions++;
               for (k = 1; k < WINDOW_SLOTS; k++) window[k-1] = window[k];
               fill = WINDOW_SLOTS - 1;
            end
            window[fill] = cur;
            fill++;
         end else begin
            dropped++;
         end
      end
      if (awaited_emits.size() > queued_before) begin
         tail = awaited_emits[awaited_emits.size() - 1];
         tail.last = 1'b1;
         awaited_emits[awaited_emits.size() - 1] = tail;
      end
   endfunction

   function void log_mismatch(string what, csw_rsp_type want, csw_rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $write("ERROR %s: expected q=%h s=%h len=%h score=%h early=%b last=%b, ", what,
                want.out_q_start, want.out_s_start, want.out_length, want.out_score,
                want.early_evicted, want.last);
         $display("got q=%h s=%h len=%h score=%h early=%b last=%b", got.out_q_start,
                  got.out_s_start, got.out_length, got.out_score, got.early_evicted,
                  got.last);
      end
   endfunction

   // Compare one accepted result beat with the oldest awaited one
   function void check_emit(csw_rsp_type got);
      csw_rsp_type want;
      emits_checked++;
      if (awaited_emits.size() == 0) begin
         log_mismatch("beat with nothing awaited", '0, got);
         return;
      end
      want = awaited_emits.pop_front();
      if (got.out_q_start !== want.out_q_start ||
          got.out_s_start !== want.out_s_start ||
          got.out_length !== want.out_length || got.out_score !== want.out_score ||
          got.early_evicted !== want.early_evicted || got.last !== want.last)
         log_mismatch("field mismatch", want, got);
   endfunction
endclass

module testbench;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 2 * WINDOW_SLOTS + 8;
   localparam int PHASE_BUDGET = 115;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   csw_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   csw_rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSW_LIMIT_WIDTH-1:0] csr_wr_data = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic rsp_hold = 1'b0;
   logic hold_armed = 1'b0;
   logic [CSW_LIMIT_WIDTH-1:0] last_limit;
   int unsigned i;

   segment_window_tracker tracker = new();

   covered_segment_window_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Result side: check accepted beats, then choose next cycle's stall
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) tracker.check_emit(rsp_data);
         rsp_stall <= rsp_hold || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Long receiver hold-off, counted here so the sender keeps pushing
   initial begin
      wait (hold_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #2000000;
      $display("covered_segment_window_filter: mismatch");
      $finish;
   end

   function automatic csw_req_type segment_beat(logic [CSW_FIELD_WIDTH-1:0] q,
                                                logic [CSW_FIELD_WIDTH-1:0] s,
                                                logic [CSW_FIELD_WIDTH-1:0] len,
                                                logic [CSW_FIELD_WIDTH-1:0] score);
      csw_req_type b;
      b.func = FUNC_SEGMENT;
      b.q_start = q;
      b.s_start = s;
      b.seg_length = len;
      b.seg_score = score;
      return b;
   endfunction

   // Random beat of either kind; flush carries junk in its other fields
   function automatic csw_req_type noise_beat(logic func);
      csw_req_type b;
      b.func = func;
      b.q_start = CSW_FIELD_WIDTH'($urandom);
      b.s_start = CSW_FIELD_WIDTH'($urandom);
      b.seg_length = CSW_FIELD_WIDTH'($urandom);
      b.seg_score = CSW_FIELD_WIDTH'($urandom);
      return b;
   endfunction

   task automatic send_item(csw_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_item(item);
   endtask

   task automatic write_cover_limit(logic [CSW_LIMIT_WIDTH-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.cover_limit = value;
   endtask

   // Let every awaited beat arrive, then give the block time to finish its walk
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.awaited_emits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly sorted segment sets closed by a flush, with some noise in between
   task automatic run_random(int unsigned budget);
      int unsigned sent, n, k;
      set_style_type style;
      logic [CSW_FIELD_WIDTH-1:0] s, len, score;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 78) begin
            n = $urandom_range(1, 45);
            if (n > budget - sent) n = budget - sent;
            style = set_style_type'($urandom_range(0, 3));
            s = CSW_FIELD_WIDTH'($urandom_range(0, 60000));
            score = CSW_FIELD_WIDTH'($urandom_range(0, 2000));
            for (k = 0; k < n; k++) begin
               case (style)
                  SET_CROWDED: begin
                     s = s + CSW_FIELD_WIDTH'($urandom_range(0, 4));
                     len = CSW_FIELD_WIDTH'($urandom_range(0, 12));
                     score = CSW_FIELD_WIDTH'($urandom_range(0, 7));
                  end
                  // rising scores never cover, so the window fills and evicts
                  SET_LONG_LIVED: begin
                     s = s + CSW_FIELD_WIDTH'($urandom_range(0, 2));
                     len = CSW_FIELD_WIDTH'($urandom_range(2000, 65535));
                     score = score + CSW_FIELD_WIDTH'($urandom_range(1, 50));
                  end
                  SET_SCATTERED: begin
                     s = s + CSW_FIELD_WIDTH'($urandom_range(0, 300));
                     len = CSW_FIELD_WIDTH'($urandom);
                     score = CSW_FIELD_WIDTH'($urandom);
                  end
                  default: begin
                     s = s + CSW_FIELD_WIDTH'($urandom_range(0, 20));
                     len = CSW_FIELD_WIDTH'($urandom_range(0, 400));
                     score = CSW_FIELD_WIDTH'($urandom_range(0, 40));
                  end
               endcase
               send_item(segment_beat(CSW_FIELD_WIDTH'($urandom), s, len, score));
               sent++;
            end
            send_item(noise_beat(FUNC_FLUSH));
            sent++;
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_item(noise_beat(1'($urandom_range(0, 1))));
               sent++;
            end
         end
      end
      settle();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset cover limit of 8
      send_idle_pct = 7;
      recv_idle_pct = 58;
      send_item(noise_beat(FUNC_FLUSH));
      // nine wide segments, alike but for q_start, are kept, the tenth has nine covers
      for (i = 0; i < 10; i++)
         send_item(segment_beat(CSW_FIELD_WIDTH'(16'hFFFF - i), '0, '1, '1));
      send_item(segment_beat(16'h1234, 16'd100, 16'd10, '0));
      // top start position expires the whole window
      send_item(segment_beat('1, '1, '1, '0));
      send_item(segment_beat('0, '1, '0, '1));
      send_item(noise_beat(FUNC_FLUSH));
      // zero length: its end equals the next start, so it expires
      send_item(segment_beat(16'd7, 16'd5, '0, 16'd3));
      send_item(segment_beat(16'd8, 16'd5, '0, 16'd3));
      // subject start going backwards
      send_item(segment_beat(16'd9, 16'd3, 16'd40, '0));
      send_item(noise_beat(FUNC_FLUSH));
      settle();

      // Sender mostly busy, receiver often stalling; no covers tolerated
      write_cover_limit('0);
      run_random(PHASE_BUDGET);

      // Sender often idle, receiver mostly ready; every segment kept
      send_idle_pct = 58;
      recv_idle_pct = 7;
      write_cover_limit(7'd64);
      run_random(PHASE_BUDGET);

      // No idling apart from one long receiver hold-off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      last_limit = CSW_LIMIT_WIDTH'($urandom_range(1, 63));
      write_cover_limit(last_limit);
      hold_armed = 1'b1;
      run_random(PHASE_BUDGET);

      if (tracker.awaited_emits.size() != 0) begin
         tracker.mismatches += tracker.awaited_emits.size();
         $display("ERROR %0d result beats never arrived", tracker.awaited_emits.size());
      end
      $display("Sent %0d input beats (%0d flushes) at cover limits 8, 0, 64 and %0d,",
               tracker.items_taken, tracker.flushes, last_limit);
      $display("%0d-cycle result hold-off; %0d beats checked, %0d dropped, %0d evicted.",
               HOLD_CYCLES, tracker.emits_checked, tracker.dropped, tracker.evictions);
      if (tracker.mismatches == 0)
         $display("covered_segment_window_filter: match");
      else
         $display("covered_segment_window_filter: mismatch");
      $finish;
   end
endmodule
